@@ rtl/core/fsgr_pkg.sv @@
// Shared types and constants of the frame store geometric remap unit.
package fsgr_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_OPERATION     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ROTATION      = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ZOOM_QUARTER  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_QUARTER_ORDER = 2'd3;

  localparam int unsigned CfgDataW = 8;
  localparam int unsigned PixelW   = 8;
  localparam int unsigned CoordW   = 8;

  // Operation codes.
  localparam logic [2:0] OP_PASS    = 3'd0;
  localparam logic [2:0] OP_INVERT  = 3'd1;
  localparam logic [2:0] OP_ROTATE  = 3'd2;
  localparam logic [2:0] OP_ENLARGE = 3'd3;
  localparam logic [2:0] OP_SHUFFLE = 3'd4;

  // Rotation codes.
  localparam logic [1:0] ROT_90  = 2'd0;
  localparam logic [1:0] ROT_180 = 2'd1;
  localparam logic [1:0] ROT_270 = 2'd2;

  // Identity quarter order: destination quarter d takes source quarter d.
  localparam logic [7:0] QUARTER_ORDER_RESET = 8'd228;
  localparam logic [PixelW-1:0] PIXEL_MAX = 8'd255;

  typedef struct packed {
    logic [2:0] operation;
    logic [1:0] rotation;
    logic [1:0] zoom_quarter;
    logic [7:0] quarter_order;
  } cfg_t;

endpackage

@@ rtl/core/fsgr_ram.sv @@
// Generic single-port RAM with registered read data.
module fsgr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/fsgr_cfg.sv @@
// Configuration register file of the frame store geometric remap unit.
module fsgr_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fsgr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [fsgr_pkg::CfgDataW-1:0]    cfg_data_i,
  output fsgr_pkg::cfg_t                   cfg_o
);
  import fsgr_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_OPERATION:     cfg_d.operation     = cfg_data_i[2:0];
        REG_ROTATION:      cfg_d.rotation      = cfg_data_i[1:0];
        REG_ZOOM_QUARTER:  cfg_d.zoom_quarter  = cfg_data_i[1:0];
        REG_QUARTER_ORDER: cfg_d.quarter_order = cfg_data_i[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.operation     <= OP_PASS;
      cfg_q.rotation      <= ROT_90;
      cfg_q.zoom_quarter  <= 2'd0;
      cfg_q.quarter_order <= QUARTER_ORDER_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/fsgr_remap.sv @@
// Source address computation for the selected geometric operation.
module fsgr_remap #(
  parameter int unsigned SIDE = 256
) (
  input  fsgr_pkg::cfg_t                    cfg_i,
  input  logic [fsgr_pkg::CoordW-1:0]       row_i,
  input  logic [fsgr_pkg::CoordW-1:0]       column_i,
  output logic [$clog2(SIDE*SIDE)-1:0]      addr_o,
  output logic                              in_range_o,
  output logic                              invert_o
);
  import fsgr_pkg::*;

  localparam int unsigned CW = $clog2(SIDE);
  localparam int unsigned AW = $clog2(SIDE*SIDE);
  localparam logic [CW-1:0] Last = CW'(SIDE - 1);
  localparam logic [CW-1:0] Half = CW'(SIDE / 2);
  localparam logic [AW-1:0] SideA = AW'(SIDE);

  logic [CW-1:0] r, c, sr, sc, lr, lc;
  logic          dr, dc;
  logic [7:0]    order_sh;
  logic [1:0]    src_quarter;

  assign r = CW'(row_i);
  assign c = CW'(column_i);

  assign in_range_o = ({24'd0, row_i} < 32'(SIDE)) && ({24'd0, column_i} < 32'(SIDE));
  assign invert_o   = (cfg_i.operation == OP_INVERT);

  // Quarter shuffle helpers.
  assign dr          = (r >= Half);
  assign dc          = (c >= Half);
  assign order_sh    = cfg_i.quarter_order >> {dr, dc, 1'b0};
  assign src_quarter = order_sh[1:0];
  assign lr          = dr ? (r - Half) : r;
  assign lc          = dc ? (c - Half) : c;

  always_comb begin
    sr = r;
    sc = c;
    case (cfg_i.operation)
      OP_ROTATE: begin
        case (cfg_i.rotation)
          ROT_90: begin
            sr = Last - c;
            sc = r;
          end
          ROT_180: begin
            sr = Last - r;
            sc = Last - c;
          end
          ROT_270: begin
            sr = c;
            sc = Last - r;
          end
          default: begin
            sr = r;
            sc = c;
          end
        endcase
      end
      OP_ENLARGE: begin
        sr = (r >> 1) + (cfg_i.zoom_quarter[1] ? Half : '0);
        sc = (c >> 1) + (cfg_i.zoom_quarter[0] ? Half : '0);
      end
      OP_SHUFFLE: begin
        sr = lr + (src_quarter[1] ? Half : '0);
        sc = lc + (src_quarter[0] ? Half : '0);
      end
      default: begin
        sr = r;
        sc = c;
      end
    endcase
  end

  assign addr_o = AW'(sr) * SideA + AW'(sc);

endmodule

@@ rtl/core/frame_store_geometric_remap_unit.sv @@
// Top level of the frame store geometric remap unit.
//
// The block holds a SIDE x SIDE store of 8-bit gray pixels in one single-port
// synchronous RAM. Input words arrive on the s_axis channel: tuser is the mode
// (0 write, 1 read) and tdata carries row, column and pixel_in. A write word
// stores pixel_in at (row, column) and produces no output word. A read word
// returns, on the m_axis channel, the pixel at (row, column) of the stored
// image as seen through the operation selected in the configuration
// registers (pass, invert, rotate, enlarge a quarter, shuffle quarters).
// Coordinates outside the frame are dropped on a write and read as zero.
//
// One word is accepted per clock while s_axis_tready is high. A read word is
// read by the RAM into its output register as it is accepted, and the output
// register then loads the pixel for m_axis. The single RAM port sets that rate.
// When the receiver stalls, the output register holds its word, a read in
// flight holds in the RAM output, and s_axis_tready then drops until space opens.
//
// Reset clears the pipeline valid flags and loads the register defaults; the
// store stays undefined until written. Configuration writes on the cfg channel
// are always taken and must only be issued while no read is outstanding.
module frame_store_geometric_remap_unit #(
  parameter int unsigned SIDE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // row [7:0], column [15:8], pixel_in [23:16]
  input  logic [0:0]  s_axis_tuser,   // mode [0]
  // Output words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // pixel_out [7:0]
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fsgr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fsgr_pkg::CfgDataW-1:0] cfg_data_i
);
  import fsgr_pkg::*;

  localparam int unsigned AW = $clog2(SIDE*SIDE);

  cfg_t            cfg;
  logic [AW-1:0]   addr;
  logic            in_range, invert;
  logic            s_fire, is_read, advance;
  logic            ram_en, ram_we;
  logic [PixelW-1:0] ram_rdata;

  // Read stage: a read word whose RAM access is in flight.
  logic            p1_q, p1_d;
  logic            p1_in_range_q, p1_invert_q;
  // Output register.
  logic            m_valid_q, m_valid_d;
  logic [PixelW-1:0] m_data_q, m_data_d;

  fsgr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fsgr_remap #(.SIDE(SIDE)) u_remap (
    .cfg_i      (cfg),
    .row_i      (s_axis_tdata[7:0]),
    .column_i   (s_axis_tdata[15:8]),
    .addr_o     (addr),
    .in_range_o (in_range),
    .invert_o   (invert)
  );

  // Write words store at their own coordinates; read words use the remapped
  // address. Both go through the same port, one access per cycle.
  logic [AW-1:0] wr_addr;
  assign wr_addr = AW'(s_axis_tdata[7:0]) * AW'(SIDE) + AW'(s_axis_tdata[15:8]);

  assign advance       = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !p1_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign is_read       = s_axis_tuser[0];
  assign ram_en        = s_fire && in_range;
  assign ram_we        = !is_read;

  fsgr_ram #(.WIDTH(PixelW), .DEPTH(SIDE*SIDE)) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (is_read ? addr : wr_addr),
    .wdata_i (s_axis_tdata[23:16]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    p1_d      = p1_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (s_axis_tready) begin
      p1_d = s_fire && is_read;
    end
    if (advance) begin
      m_valid_d = p1_q;
      if (p1_q) begin
        if (!p1_in_range_q) begin
          m_data_d = '0;
        end else if (p1_invert_q) begin
          m_data_d = PIXEL_MAX - ram_rdata;
        end else begin
          m_data_d = ram_rdata;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      p1_q      <= p1_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      p1_in_range_q <= in_range;
      p1_invert_q   <= invert;
    end
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTH
  // A stalled read in flight must block new words, or the RAM output is lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_q && !advance |-> !s_axis_tready)
    else $error("input accepted while read stage is stalled");

  // An accepted read word occupies the read stage in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && is_read |=> p1_q)
    else $error("accepted read word did not enter the read stage");

  // A write word never enters the read stage, so it produces no output word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !is_read |=> !p1_q)
    else $error("write word entered the read stage");

  // Every new output word comes from the read stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(p1_q))
    else $error("output word appeared without a read in flight");

  // A read outside the frame returns zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_q && !p1_in_range_q && advance |=> m_data_q == '0)
    else $error("out-of-frame read returned nonzero pixel");
`endif

endmodule
